FILE: design/kce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 4;

    // request codes
    localparam logic [1:0] REQ_EVAL   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_MODE   = 2'd3;

    // segment interpolation modes
    localparam logic [1:0] MODE_HOLD_L = 2'd0;
    localparam logic [1:0] MODE_HOLD_R = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;
    localparam logic [1:0] MODE_EASE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 4'd1;

    localparam logic [DATA_W-1:0] START_RESET = 32'd0;
    localparam logic [DATA_W-1:0] END_RESET   = 32'd6553600;

    // write enables toward the key memories
    typedef struct packed {
        logic pos_we;
        logic lvl_we;
    } t_mem_we;

endpackage

FILE: design/kce_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_mem
// Key storage: position memory and level/mode memory, one write port and
// two registered read ports each, shared addresses.
// ----------------------------------------------------------------------------
module kce_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                              i_clk,
    input  kce_pkg::t_mem_we                  i_we,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [kce_pkg::DATA_W-1:0]        i_wr_pos,
    input  logic [kce_pkg::DATA_W+1:0]        i_wr_lvl,
    input  logic [AW-1:0]                     i_rd_addr_a,
    input  logic [AW-1:0]                     i_rd_addr_b,
    output logic [kce_pkg::DATA_W-1:0]        o_pos_a,
    output logic [kce_pkg::DATA_W-1:0]        o_pos_b,
    output logic [kce_pkg::DATA_W+1:0]        o_lvl_a,
    output logic [kce_pkg::DATA_W+1:0]        o_lvl_b
);

    logic [kce_pkg::DATA_W-1:0] m_pos [DEPTH];
    logic [kce_pkg::DATA_W+1:0] m_lvl [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we.pos_we) begin
            m_pos[i_wr_addr] <= i_wr_pos;
        end
        if (i_we.lvl_we) begin
            m_lvl[i_wr_addr] <= i_wr_lvl;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_pos_a <= m_pos[i_rd_addr_a];
        o_pos_b <= m_pos[i_rd_addr_b];
        o_lvl_a <= m_lvl[i_rd_addr_a];
        o_lvl_b <= m_lvl[i_rd_addr_b];
    end

endmodule

FILE: design/kce_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_div
// Restoring divider for the segment rate, one quotient bit per cycle.
// Expects num <= den, so the quotient fits FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module kce_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [32:0]                   i_num,
    input  logic [32:0]                   i_den,
    output logic [kce_pkg::FRAC_BITS:0]   o_quot,
    output logic                          o_done
);

    localparam int TW = kce_pkg::FRAC_BITS + 1;
    localparam int NW = $clog2(TW + 1);

    logic [32:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_nb;
    logic [TW-1:0] r_quot;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [33:0]   shifted;
    logic [33:0]   trial;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_nb};
        trial   = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse after the last quotient bit
            r_done <= !i_start && r_busy && (r_cnt == NW'(TW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num[32:1]};
                r_nb   <= i_num[0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_nb <= 1'b0;
                if (!trial[33]) begin
                    r_rem  <= trial[32:0];
                    r_quot <= {r_quot[TW-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted[32:0];
                    r_quot <= {r_quot[TW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(TW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

FILE: design/keyframe_curve_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_top
// Sorted keyframe table with per-segment interpolation: evaluate, insert,
// remove and set-mode requests served by a sequencer around the key memories.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        request    i_in_valid / o_in_ready     type, position, value, index, mode
//  out       result     o_out_valid / i_out_ready   status, value, segment, points
//  cfg       write      i_cfg_valid / o_cfg_ready   index, data
//
//  sequence: search uses a read state and a compare state per binary step;
//  a linear or ease evaluate adds the divider, then S_EVEASE (ease only), S_EVLERP
//  and S_EVFIN; insert and remove add a shift step per moved entry; set mode
//  reads in S_MODERD and writes in S_MODEWR; each result passes through
//  S_DONE into the output register.
//  reset: S_INIT0 and S_INIT1 write both end keyframes before requests are taken.
//  stalls: a new request is taken while a result waits; the next result
//  waits in S_DONE until the output register frees.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator_top #(
    parameter int MAX_KEYS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic signed [31:0]                   i_position,
    input  logic signed [31:0]                   i_key_value,
    input  logic [5:0]                           i_target_index,
    input  logic [1:0]                           i_interp_mode,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic signed [31:0]                   o_curve_value,
    output logic [5:0]                           o_segment_index,
    output logic [6:0]                           o_points_in_use,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kce_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int XW  = ((CW > 6) ? CW : 6) + 1;
    localparam int FB  = kce_pkg::FRAC_BITS;
    localparam int TW  = FB + 1;
    localparam int BW  = FB + 3;
    localparam int PEW = TW + BW;
    localparam int PLW = 33 + TW + 1;
    localparam logic [TW-1:0] T_ONE  = TW'(1) << FB;
    localparam logic [TW-1:0] T_HALF = TW'(1) << (FB - 1);
    localparam logic [BW-1:0] B_FOUR = BW'(4) << FB;

    typedef enum logic [14:0] {
        S_INIT0   = 15'b000000000000001,
        S_INIT1   = 15'b000000000000010,
        S_IDLE    = 15'b000000000000100,
        S_SRD     = 15'b000000000001000,
        S_SCMP    = 15'b000000000010000,
        S_EVDIV   = 15'b000000000100000,
        S_EVEASE  = 15'b000000001000000,
        S_EVLERP  = 15'b000000010000000,
        S_EVFIN   = 15'b000000100000000,
        S_INSSH   = 15'b000001000000000,
        S_REMSH   = 15'b000010000000000,
        S_MODERD  = 15'b000100000000000,
        S_MODEWR  = 15'b001000000000000,
        S_DONE    = 15'b010000000000000,
        S_SPARE   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // request and table registers
    logic [1:0]         r_req;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_val;
    logic [5:0]         r_idx;
    logic [1:0]         r_mode_in;
    logic [31:0]        r_start;
    logic [31:0]        r_end;
    logic [CW-1:0]      r_pts;
    logic [AW-1:0]      r_l;
    logic [AW-1:0]      r_r;
    logic [AW-1:0]      r_seg;
    logic signed [31:0] r_y1;
    logic signed [31:0] r_y2;
    logic [1:0]         r_smode;
    logic [TW-1:0]      r_t;
    logic               r_tbig;
    logic [PEW-1:0]     r_prod_e;
    logic signed [PLW-1:0] r_prod_l;
    logic [CW-1:0]      r_nxt;
    logic [AW-1:0]      r_dst;
    logic               r_pipe;
    logic [1:0]         r_res_status;
    logic signed [31:0] r_res_value;
    logic [AW-1:0]      r_res_seg;
    logic               r_ov;
    logic [1:0]         r_o_status;
    logic signed [31:0] r_o_value;
    logic [AW-1:0]      r_o_seg;
    logic [CW-1:0]      r_o_pts;

    // memory signals
    kce_pkg::t_mem_we   mem_we;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_pos;
    logic [33:0]        wr_lvl;
    logic [AW-1:0]      rd_a;
    logic [AW-1:0]      rd_b;
    logic signed [31:0] pos_a;
    logic signed [31:0] pos_b;
    logic [33:0]        lvl_a;
    logic [33:0]        lvl_b;

    // search and misc datapath
    logic [AW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [AW-1:0]      mid1;
    logic               in_acc;
    logic               cfg_acc;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      pts_x;
    logic               rem_bad;
    logic               mode_bad;
    logic [CW-1:0]      ins_at;
    logic               ins_launch;
    logic               rem_launch;
    logic               div_start;
    logic [32:0]        div_num;
    logic [32:0]        div_den;
    logic [TW-1:0]      div_quot;
    logic               div_done;
    logic [BW-1:0]      ease_b;
    logic [PEW-1:0]     e_shift;
    logic [TW-1:0]      ease_e;
    logic [TW-1:0]      lerp_w;
    logic signed [32:0] lerp_d;
    logic signed [PLW-1:0] lerp_sh;
    logic               found;
    logic               out_load;

    kce_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (mem_we),
        .i_wr_addr   (wr_addr),
        .i_wr_pos    (wr_pos),
        .i_wr_lvl    (wr_lvl),
        .i_rd_addr_a (rd_a),
        .i_rd_addr_b (rd_b),
        .o_pos_a     (pos_a),
        .o_pos_b     (pos_b),
        .o_lvl_a     (lvl_a),
        .o_lvl_b     (lvl_b)
    );

    kce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    // handshakes
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_ov || i_out_ready);

    // index checks for remove and set mode
    always_comb begin
        idx_x    = XW'(i_target_index);
        pts_x    = XW'(r_pts);
        rem_bad  = (i_target_index == 6'd0) || (idx_x + XW'(1) >= pts_x);
        mode_bad = (idx_x + XW'(1) >= pts_x);
    end

    // binary search midpoint
    always_comb begin
        mid_sum = {1'b0, r_l} + {1'b0, r_r};
        mid     = mid_sum[AW:1];
        mid1    = mid + AW'(1);
        found   = !(r_pos < pos_a) && !(r_pos > pos_b);
    end

    // shift loop controls
    always_comb begin
        ins_at     = CW'(r_seg) + CW'(1);
        ins_launch = (r_nxt > ins_at);
        rem_launch = (r_nxt + CW'(1) < r_pts);
    end

    // divider operands, valid in the compare cycle
    always_comb begin
        div_num   = 33'({r_pos[31], r_pos} - {pos_a[31], pos_a});
        div_den   = 33'({pos_b[31], pos_b} - {pos_a[31], pos_a});
        div_start = (r_state == S_SCMP) && found && (r_req == kce_pkg::REQ_EVAL)
                    && lvl_a[1] && (pos_b > pos_a);
    end

    // ease and lerp operands
    always_comb begin
        ease_b  = (r_t <= T_HALF) ? BW'({r_t, 1'b0}) : (B_FOUR - BW'({r_t, 1'b0}));
        e_shift = r_prod_e >> FB;
        ease_e  = TW'(e_shift) - (r_tbig ? T_ONE : TW'(0));
        lerp_w  = (r_smode == kce_pkg::MODE_EASE) ? ease_e : r_t;
        lerp_d  = 33'(r_y2) - 33'(r_y1);
        lerp_sh = r_prod_l >>> FB;
    end

    // memory read addresses
    always_comb begin
        rd_a = mid;
        rd_b = mid1;
        priority case (1'b1)
            (r_state == S_INSSH):  rd_a = AW'(r_nxt - CW'(1));
            (r_state == S_REMSH):  rd_a = AW'(r_nxt + CW'(1));
            (r_state == S_MODERD): rd_a = AW'(r_idx);
            default:               rd_a = mid;
        endcase
    end

    // memory write port
    always_comb begin
        mem_we  = '0;
        wr_addr = '0;
        wr_pos  = pos_a;
        wr_lvl  = lvl_a;
        unique case (r_state)
            S_INIT0: begin
                mem_we  = '{pos_we: 1'b1, lvl_we: 1'b1};
                wr_addr = '0;
                wr_pos  = r_start;
                wr_lvl  = {32'd0, kce_pkg::MODE_HOLD_L};
            end
            S_INIT1: begin
                mem_we  = '{pos_we: 1'b1, lvl_we: 1'b1};
                wr_addr = AW'(1);
                wr_pos  = r_end;
                wr_lvl  = {32'd0, kce_pkg::MODE_HOLD_L};
            end
            S_IDLE: begin
                if (cfg_acc && i_cfg_index == kce_pkg::CFG_START) begin
                    mem_we.pos_we = 1'b1;
                    wr_addr       = '0;
                    wr_pos        = i_cfg_data;
                end else if (cfg_acc && i_cfg_index == kce_pkg::CFG_END) begin
                    mem_we.pos_we = 1'b1;
                    wr_addr       = AW'(r_pts - CW'(1));
                    wr_pos        = i_cfg_data;
                end
            end
            S_INSSH: begin
                if (r_pipe) begin
                    mem_we  = '{pos_we: 1'b1, lvl_we: 1'b1};
                    wr_addr = r_dst;
                end else if (!ins_launch) begin
                    mem_we  = '{pos_we: 1'b1, lvl_we: 1'b1};
                    wr_addr = AW'(ins_at);
                    wr_pos  = r_pos;
                    wr_lvl  = {r_val, kce_pkg::MODE_HOLD_L};
                end
            end
            S_REMSH: begin
                if (r_pipe) begin
                    mem_we  = '{pos_we: 1'b1, lvl_we: 1'b1};
                    wr_addr = r_dst;
                end
            end
            S_MODEWR: begin
                mem_we.lvl_we = 1'b1;
                wr_addr       = AW'(r_idx);
                wr_lvl        = {lvl_a[33:2], r_mode_in};
            end
            default: begin
                mem_we = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT0: n_state = S_INIT1;
            S_INIT1: n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    priority case (1'b1)
                        (i_req_type == kce_pkg::REQ_REMOVE):
                            n_state = rem_bad ? S_DONE : S_REMSH;
                        (i_req_type == kce_pkg::REQ_MODE):
                            n_state = mode_bad ? S_DONE : S_MODERD;
                        default:
                            n_state = S_SRD;
                    endcase
                end
            end
            S_SRD:   n_state = (r_l < r_r) ? S_SCMP : S_DONE;
            S_SCMP: begin
                if (!found) begin
                    n_state = S_SRD;
                end else if (r_req == kce_pkg::REQ_INSERT) begin
                    n_state = (r_pts >= CW'(MAX_KEYS)) ? S_DONE : S_INSSH;
                end else begin
                    n_state = div_start ? S_EVDIV : S_DONE;
                end
            end
            S_EVDIV: begin
                if (div_done) begin
                    n_state = (r_smode == kce_pkg::MODE_EASE) ? S_EVEASE : S_EVLERP;
                end
            end
            S_EVEASE: n_state = S_EVLERP;
            S_EVLERP: n_state = S_EVFIN;
            S_EVFIN:  n_state = S_DONE;
            S_INSSH:  n_state = (!r_pipe && !ins_launch) ? S_DONE : S_INSSH;
            S_REMSH:  n_state = (!r_pipe && !rem_launch) ? S_DONE : S_REMSH;
            S_MODERD: n_state = S_MODEWR;
            S_MODEWR: n_state = S_DONE;
            S_DONE:   n_state = out_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
            r_start <= kce_pkg::START_RESET;
            r_end   <= kce_pkg::END_RESET;
            r_pts   <= CW'(2);
            r_pipe  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration registers
            if (cfg_acc && i_cfg_index == kce_pkg::CFG_START) begin
                r_start <= i_cfg_data;
            end
            if (cfg_acc && i_cfg_index == kce_pkg::CFG_END) begin
                r_end <= i_cfg_data;
            end

            // request capture
            if (in_acc) begin
                r_req        <= i_req_type;
                r_pos        <= i_position;
                r_val        <= i_key_value;
                r_idx        <= i_target_index;
                r_mode_in    <= i_interp_mode;
                r_l          <= '0;
                r_r          <= AW'(r_pts - CW'(1));
                r_nxt        <= (i_req_type == kce_pkg::REQ_REMOVE) ?
                                CW'(i_target_index) : r_pts;
                r_pipe       <= 1'b0;
                r_res_value  <= '0;
                r_res_seg    <= '0;
                r_res_status <= ((i_req_type == kce_pkg::REQ_REMOVE && rem_bad) ||
                                 (i_req_type == kce_pkg::REQ_MODE && mode_bad)) ?
                                kce_pkg::ST_INDEX : kce_pkg::ST_OK;
            end

            // search steps
            if (r_state == S_SRD && !(r_l < r_r)) begin
                r_res_status <= kce_pkg::ST_RANGE;
            end
            if (r_state == S_SCMP) begin
                if (r_pos < pos_a) begin
                    r_r <= mid;
                end else if (r_pos > pos_b) begin
                    r_l <= mid1;
                end else begin
                    r_seg   <= mid;
                    r_y1    <= lvl_a[33:2];
                    r_y2    <= lvl_b[33:2];
                    r_smode <= lvl_a[1:0];
                    if (r_req == kce_pkg::REQ_INSERT) begin
                        if (r_pts >= CW'(MAX_KEYS)) begin
                            r_res_status <= kce_pkg::ST_FULL;
                        end else begin
                            r_res_seg <= mid;
                        end
                    end else begin
                        r_res_seg <= mid;
                        if (lvl_a[1:0] == kce_pkg::MODE_HOLD_R) begin
                            r_res_value <= lvl_b[33:2];
                        end else begin
                            r_res_value <= lvl_a[33:2];
                        end
                    end
                end
            end

            // evaluate arithmetic
            if (r_state == S_EVDIV && div_done) begin
                r_t <= div_quot;
            end
            if (r_state == S_EVEASE) begin
                r_prod_e <= PEW'(r_t) * PEW'(ease_b);
                r_tbig   <= (r_t > T_HALF);
            end
            if (r_state == S_EVLERP) begin
                r_prod_l <= PLW'(lerp_d) * $signed(PLW'({1'b0, lerp_w}));
            end
            if (r_state == S_EVFIN) begin
                r_res_value <= r_y1 + 32'(lerp_sh);
            end

            // insert shift loop, downward
            if (r_state == S_INSSH) begin
                if (ins_launch) begin
                    r_dst  <= AW'(r_nxt);
                    r_nxt  <= r_nxt - CW'(1);
                    r_pipe <= 1'b1;
                end else begin
                    r_pipe <= 1'b0;
                end
                if (!r_pipe && !ins_launch) begin
                    r_pts <= r_pts + CW'(1);
                end
            end

            // remove shift loop, upward
            if (r_state == S_REMSH) begin
                if (rem_launch) begin
                    r_dst  <= AW'(r_nxt);
                    r_nxt  <= r_nxt + CW'(1);
                    r_pipe <= 1'b1;
                end else begin
                    r_pipe <= 1'b0;
                end
                if (!r_pipe && !rem_launch) begin
                    r_pts <= r_pts - CW'(1);
                end
            end

            // output register
            if (out_load) begin
                r_ov       <= 1'b1;
                r_o_status <= r_res_status;
                r_o_value  <= r_res_value;
                r_o_seg    <= r_res_seg;
                r_o_pts    <= r_pts;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_curve_value   = r_o_value;
    assign o_segment_index = 6'(r_o_seg);
    assign o_points_in_use = 7'(r_o_pts);

endmodule

FILE: design/kce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_checker
// Port-level checks of the keyframe curve evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module kce_checker #(
    parameter int MAX_KEYS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_cfg_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_curve_value,
    input logic [5:0]  o_segment_index,
    input logic [6:0]  o_points_in_use
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_curve_value)
        && $stable(o_status) && $stable(o_points_in_use))
        else $error("result changed while stalled");

    // failed requests give zero value and segment
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != kce_pkg::ST_OK |->
        o_curve_value == 32'd0 && o_segment_index == 6'd0)
        else $error("nonzero payload on failed request");

    // point count stays in range
    a_pts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_points_in_use >= 7'd2
        && 32'(o_points_in_use) <= MAX_KEYS)
        else $error("point count out of range");

    // requests are taken only when configuration may be written
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> o_cfg_ready)
        else $error("request ready outside idle");

endmodule

bind keyframe_curve_evaluator_top kce_checker #(
    .MAX_KEYS (MAX_KEYS)
) u_kce_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_cfg_ready     (o_cfg_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_curve_value   (o_curve_value),
    .o_segment_index (o_segment_index),
    .o_points_in_use (o_points_in_use)
);

FILE: dv/keyframe_curve_evaluator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_top_test
// Drives evaluate, insert, remove and set-mode requests into the keyframe
// curve evaluator under random stalls on both channels. Every result is
// compared field by field with a behavioral model of the keyframe table.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator_top_test;

    localparam int TABLE_KEYS = 64;
    localparam longint Q_ONE  = 64'sd1 << kce_pkg::FRAC_BITS;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] pos;
        logic [31:0] val;
        logic [5:0]  idx;
        logic [1:0]  mode;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] level;
        logic [5:0]  seg;
        logic [6:0]  points;
    } t_result;

    // directed row: request, optional typed-in result
    typedef struct packed {
        t_request rq;
        logic     typed;
        t_result  res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic signed [31:0] i_position;
    logic signed [31:0] i_key_value;
    logic [5:0]  i_target_index;
    logic [1:0]  i_interp_mode;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic signed [31:0] o_curve_value;
    logic [5:0]  o_segment_index;
    logic [6:0]  o_points_in_use;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [kce_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    // model state of the keyframe table
    longint key_x [TABLE_KEYS];
    longint key_y [TABLE_KEYS];
    logic [1:0] seg_mode [TABLE_KEYS];
    int     key_count;

    t_result pending_results[$];
    int      mismatch_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    keyframe_curve_evaluator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_key_value    (i_key_value),
        .i_target_index (i_target_index),
        .i_interp_mode  (i_interp_mode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_curve_value  (o_curve_value),
        .o_segment_index(o_segment_index),
        .o_points_in_use(o_points_in_use),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %0t %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic longint floor_q(input longint p);
        return p >>> kce_pkg::FRAC_BITS;
    endfunction

    function automatic int locate_segment(input longint x);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = key_count - 1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (x < key_x[mid]) hi = mid;
            else if (x > key_x[mid+1]) lo = mid + 1;
            else return mid;
        end
        return -1;
    endfunction

    function automatic longint interpolate(input int s, input longint x);
        longint x1, x2, y1, y2, t, e, w;
        x1 = key_x[s];
        x2 = key_x[s+1];
        y1 = key_y[s];
        y2 = key_y[s+1];
        t = 0;
        if (x2 > x1) t = ((x - x1) <<< kce_pkg::FRAC_BITS) / (x2 - x1);
        case (seg_mode[s])
            kce_pkg::MODE_HOLD_L: return y1;
            kce_pkg::MODE_HOLD_R: return y2;
            kce_pkg::MODE_LINEAR: w = t;
            default: begin
                if (t <= Q_ONE / 2) e = (2 * t * t) >>> kce_pkg::FRAC_BITS;
                else e = ((t * (4 * Q_ONE - 2 * t)) >>> kce_pkg::FRAC_BITS) - Q_ONE;
                w = e;
            end
        endcase
        return y1 + floor_q((y2 - y1) * w);
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < TABLE_KEYS; i++) begin
            key_x[i] = 0;
            key_y[i] = 0;
            seg_mode[i] = kce_pkg::MODE_HOLD_L;
        end
        key_count = 2;
        key_x[1] = 6553600;
    endfunction

    function automatic void table_config(input logic [kce_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [31:0] d);
        if (idx == kce_pkg::CFG_START) key_x[0] = longint'($signed(d));
        else if (idx == kce_pkg::CFG_END) key_x[key_count-1] = longint'($signed(d));
    endfunction

    // apply one request to the table model and return its result
    function automatic t_result table_apply(input t_request rq);
        t_result r;
        longint x;
        int s;
        int at;
        r = '0;
        x = longint'($signed(rq.pos));
        case (rq.req)
            kce_pkg::REQ_EVAL: begin
                s = locate_segment(x);
                if (s < 0) r.status = kce_pkg::ST_RANGE;
                else begin
                    r.level = 32'(interpolate(s, x));
                    r.seg = 6'(s);
                end
            end
            kce_pkg::REQ_INSERT: begin
                s = locate_segment(x);
                if (s < 0) r.status = kce_pkg::ST_RANGE;
                else if (key_count >= TABLE_KEYS) r.status = kce_pkg::ST_FULL;
                else begin
                    at = s + 1;
                    for (int i = key_count; i > at; i--) begin
                        key_x[i] = key_x[i-1];
                        key_y[i] = key_y[i-1];
                        seg_mode[i] = seg_mode[i-1];
                    end
                    key_x[at] = x;
                    key_y[at] = longint'($signed(rq.val));
                    seg_mode[at] = kce_pkg::MODE_HOLD_L;
                    key_count++;
                    r.seg = 6'(s);
                end
            end
            kce_pkg::REQ_REMOVE: begin
                if (rq.idx == 0 || int'(rq.idx) + 1 >= key_count) r.status = kce_pkg::ST_INDEX;
                else begin
                    for (int i = rq.idx; i + 1 < key_count; i++) begin
                        key_x[i] = key_x[i+1];
                        key_y[i] = key_y[i+1];
                        seg_mode[i] = seg_mode[i+1];
                    end
                    key_count--;
                    key_x[key_count] = 0;
                    key_y[key_count] = 0;
                    seg_mode[key_count] = kce_pkg::MODE_HOLD_L;
                end
            end
            default: begin
                if (int'(rq.idx) + 1 >= key_count) r.status = kce_pkg::ST_INDEX;
                else seg_mode[rq.idx] = rq.mode;
            end
        endcase
        r.points = 7'(key_count);
        return r;
    endfunction

    // request sender, one item at a time, after a random idle wait
    task automatic send_request(input t_request rq);
        do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        i_in_valid     <= 1'b1;
        i_req_type     <= rq.req;
        i_position     <= rq.pos;
        i_key_value    <= rq.val;
        i_target_index <= rq.idx;
        i_interp_mode  <= rq.mode;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_register(input logic [kce_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        table_config(idx, d);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    // model is updated when the request is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_results.push_back(table_apply({i_req_type, i_position, i_key_value,
                                                   i_target_index, i_interp_mode}));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_curve_value !== want.level)
                    report_mismatch("curve_value", o_curve_value, $signed(want.level));
                if (o_segment_index !== want.seg)
                    report_mismatch("segment_index", o_segment_index, want.seg);
                if (o_points_in_use !== want.points)
                    report_mismatch("points_in_use", o_points_in_use, want.points);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_request random_request();
        t_request rq;
        int pick;
        longint lo, hi;
        rq.val  = $urandom();
        rq.mode = 2'($urandom_range(3));
        pick = $urandom_range(99);
        lo = key_x[0];
        hi = key_x[key_count-1];
        // mostly in-range positions, some anywhere
        if (pick < 80 && hi > lo) rq.pos = 32'(lo + longint'($urandom_range(0, 32'hFFFF_FFFF))
                                              % (hi - lo + 1));
        else if (pick < 88) rq.pos = 32'(key_x[$urandom_range(key_count-1)]);
        else rq.pos = $urandom();
        pick = $urandom_range(99);
        if (pick < 40) rq.req = kce_pkg::REQ_EVAL;
        else if (pick < 70) rq.req = kce_pkg::REQ_INSERT;
        else if (pick < 82) rq.req = kce_pkg::REQ_REMOVE;
        else rq.req = kce_pkg::REQ_MODE;
        if ($urandom_range(9) == 0) rq.idx = 6'($urandom());
        else rq.idx = 6'($urandom_range(key_count > 1 ? key_count - 1 : 0));
        return rq;
    endfunction

    t_row directed_rows[] = '{
        // after reset: flat table, hold left
        '{'{kce_pkg::REQ_EVAL, 32'd0, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_EVAL, 32'hFFFF_FFFF, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_RANGE, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_EVAL, 32'h7FFF_FFFF, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_RANGE, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_INSERT, 32'h8000_0000, 32'd5, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_RANGE, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_REMOVE, 32'd0, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_INDEX, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_REMOVE, 32'd0, 32'd0, 6'd63, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_INDEX, 32'd0, 6'd0, 7'd2}},
        '{'{kce_pkg::REQ_MODE, 32'd0, 32'd0, 6'd1, kce_pkg::MODE_EASE}, 1'b1,
          '{kce_pkg::ST_INDEX, 32'd0, 6'd0, 7'd2}},
        // build a curve and exercise the linear, ease and hold-right modes
        '{'{kce_pkg::REQ_INSERT, 32'd3276800, 32'h7FFF_FFFF, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd0, 7'd3}},
        '{'{kce_pkg::REQ_INSERT, 32'd4915200, 32'h8000_0000, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd1, 7'd4}},
        '{'{kce_pkg::REQ_MODE, 32'd0, 32'd0, 6'd0, kce_pkg::MODE_LINEAR}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd0, 7'd4}},
        '{'{kce_pkg::REQ_MODE, 32'd0, 32'd0, 6'd1, kce_pkg::MODE_EASE}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd0, 7'd4}},
        '{'{kce_pkg::REQ_MODE, 32'd0, 32'd0, 6'd2, kce_pkg::MODE_HOLD_R}, 1'b1,
          '{kce_pkg::ST_OK, 32'd0, 6'd0, 7'd4}},
        '{'{kce_pkg::REQ_EVAL, 32'd1000000, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd3500000, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd4500000, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd6000000, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd6553600, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        // duplicate position makes a zero-width segment
        '{'{kce_pkg::REQ_INSERT, 32'd3276800, 32'd12345, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_MODE, 32'd0, 32'd0, 6'd1, kce_pkg::MODE_LINEAR}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd3276800, 32'd0, 6'd0, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_REMOVE, 32'd0, 32'd0, 6'd2, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_REMOVE, 32'd0, 32'd0, 6'd1, kce_pkg::MODE_HOLD_L}, 1'b0, '0},
        '{'{kce_pkg::REQ_EVAL, 32'd2000000, 32'h5555_5555, 6'd42, kce_pkg::MODE_EASE},
          1'b0, '0}
    };

    initial begin
        t_result want;
        t_request rq;
        mismatch_count = 0;
        send_idle_pct  = 27;
        recv_idle_pct  = 80;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = kce_pkg::REQ_EVAL;
        i_position     = '0;
        i_key_value    = '0;
        i_target_index = '0;
        i_interp_mode  = kce_pkg::MODE_HOLD_L;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = kce_pkg::CFG_START;
        i_cfg_data     = '0;
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // typed results are checked against the model, the model against the block
        foreach (directed_rows[k]) begin
            if (directed_rows[k].typed) begin
                want = table_apply(directed_rows[k].rq);
                if (want !== directed_rows[k].res)
                    report_mismatch("directed row", k, 0);
            end
        end
        table_reset();
        foreach (directed_rows[k]) send_request(directed_rows[k].rq);
        drain_results();

        // three phases of stall rates (none in the last), each with its own end positions
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) begin
                write_register(kce_pkg::CFG_START, 32'h8000_0000);
                write_register(kce_pkg::CFG_END, 32'h7FFF_FFFF);
            end else if (ph == 1) begin
                send_idle_pct = 80;
                recv_idle_pct = 27;
                write_register(kce_pkg::CFG_START, 32'hFFFF_0000);
                write_register(kce_pkg::CFG_END, 32'h0001_0000);
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_register(kce_pkg::CFG_START, 32'd0);
                write_register(kce_pkg::CFG_END, 32'd6553600);
            end
            for (int n = 0; n < 140; n++) send_request(random_request());
            drain_results();
        end

        // fill the table to full, try one more insert, then send random requests
        send_idle_pct = 10;
        recv_idle_pct = 10;
        while (key_count < TABLE_KEYS || pending_results.size() != 0) begin
            if (key_count < TABLE_KEYS) begin
                rq = random_request();
                rq.req = kce_pkg::REQ_INSERT;
                rq.pos = 32'($urandom_range(0, 6553600));
                send_request(rq);
            end else @(posedge i_clk);
        end
        rq = random_request();
        rq.req = kce_pkg::REQ_INSERT;
        rq.pos = 32'd100;
        send_request(rq);
        for (int n = 0; n < 20; n++) begin
            rq = random_request();
            send_request(rq);
        end
        drain_results();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
